/* src/sndhtp_pkg.sv */
`default_nettype none
package sndhtp_pkg;

  localparam int TITLE_CHARS        = 64;
  localparam int AUTHOR_CHARS       = 64;
  localparam int YEAR_CHARS         = 32;
  localparam int MAGIC_SEARCH_LIMIT = 512;

  localparam logic [9:0] COUNT_MAX    = 10'd1023;
  localparam logic [9:0] MIN_FILE_LEN = 10'd16;
  localparam logic [15:0] DEFAULT_HZ  = 16'd50;
  localparam logic [6:0] DEFAULT_TUNE = 7'd1;

  localparam logic [31:0] TAG_SNDH = 32'h534E_4448;
  localparam logic [31:0] TAG_HDNS = 32'h4844_4E53;
  localparam logic [31:0] TAG_TITL = 32'h5449_544C;
  localparam logic [31:0] TAG_COMM = 32'h434F_4D4D;
  localparam logic [31:0] TAG_YEAR = 32'h5945_4152;
  localparam logic [15:0] TAG_TUNES = 16'h2323;
  localparam logic [15:0] TAG_START = 16'h2123;
  localparam logic [15:0] TAG_TC    = 16'h5443;

  localparam logic [1:0] SID_TITLE  = 2'd0;
  localparam logic [1:0] SID_AUTHOR = 2'd1;
  localparam logic [1:0] SID_YEAR   = 2'd2;
  localparam int NUM_STRINGS = 3;

  localparam logic RES_CHAR    = 1'b0;
  localparam logic RES_SUMMARY = 1'b1;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [3:0] {
    MODE_SEARCH = 4'b0001,
    MODE_TAGS   = 4'b0010,
    MODE_STRING = 4'b0100,
    MODE_DONE   = 4'b1000
  } mode_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } item_t;

  typedef struct packed {
    logic        result_type;
    logic [1:0]  string_id;
    logic [5:0]  char_index;
    logic [7:0]  char_value;
    logic        parse_ok;
    logic [6:0]  subtune_count;
    logic [6:0]  default_subtune;
    logic [15:0] timer_hz;
    logic [5:0]  title_length;
    logic [5:0]  author_length;
    logic [5:0]  year_length;
  } res_t;

  // one front-end event: an optional character and an optional summary
  typedef struct packed {
    logic        has_char;
    logic [1:0]  char_sid;
    logic [5:0]  char_idx;
    logic [7:0]  char_val;
    logic        has_sum;
    logic        sum_ok;
    logic [6:0]  sum_tunes;
    logic [6:0]  sum_start;
    logic [15:0] sum_hz;
    logic [5:0]  sum_title_len;
    logic [5:0]  sum_author_len;
    logic [5:0]  sum_year_len;
  } qent_t;

  function automatic logic [6:0] cap_of(input logic [1:0] sid);
    logic [6:0] cap;
    case (sid)
      SID_TITLE:  cap = 7'(TITLE_CHARS);
      SID_AUTHOR: cap = 7'(AUTHOR_CHARS);
      default:    cap = 7'(YEAR_CHARS);
    endcase
    return cap;
  endfunction

endpackage
`default_nettype wire

/* src/sndhtp_front.sv */
`default_nettype none
module sndhtp_front
  import sndhtp_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  in_valid_i,
  input  wire item_t in_data_i,
  output logic       in_ready_o,
  output logic       push_valid_o,
  output qent_t      push_data_o,
  input  wire logic  push_ready_i
);

  mode_e       mode_q, mode_d;
  logic [31:0] win_q, win_d;
  logic [2:0]  fill_q, fill_d;
  logic [9:0]  cnt_q, cnt_d;
  logic [1:0]  act_q, act_d;
  logic [5:0]  pos_q, pos_d;
  logic [NUM_STRINGS-1:0][5:0] len_q, len_d;
  logic [6:0]  tunes_q, tunes_d;
  logic [6:0]  start_q, start_d;
  logic [15:0] hz_q, hz_d;

  logic        fire;
  logic [7:0]  b;
  logic [31:0] shifted;
  logic [2:0]  fill_inc;
  logic [7:0]  dig_hi, dig_lo;
  logic        dig_ok;
  logic [6:0]  dig_val;
  logic        emit;
  logic        ok;
  qent_t       ent;

  assign in_ready_o   = push_ready_i;
  assign fire         = in_valid_i && in_ready_o;
  assign b            = in_data_i.data_byte;
  assign shifted      = {win_q[23:0], b};
  assign fill_inc     = (fill_q < 3'd4) ? fill_q + 3'd1 : fill_q;
  assign dig_hi       = shifted[15:8];
  assign dig_lo       = shifted[7:0];
  assign dig_ok       = (dig_hi inside {[8'h30:8'h39]}) && (dig_lo inside {[8'h30:8'h39]});
  assign dig_val      = 7'(dig_hi[3:0]) * 7'd10 + 7'(dig_lo[3:0]);
  assign push_valid_o = fire && (emit || in_data_i.last_byte);
  assign push_data_o  = ent;

  always_comb begin
    mode_d  = mode_q;
    win_d   = win_q;
    fill_d  = fill_q;
    act_d   = act_q;
    pos_d   = pos_q;
    len_d   = len_q;
    tunes_d = tunes_q;
    start_d = start_q;
    hz_d    = hz_q;
    emit    = 1'b0;
    cnt_d   = (cnt_q != COUNT_MAX) ? cnt_q + 10'd1 : cnt_q;

    case (mode_q)
      MODE_SEARCH: begin
        win_d  = shifted;
        fill_d = fill_inc;
        if (fill_inc == 3'd4 && cnt_d <= 10'(MAGIC_SEARCH_LIMIT) && shifted == TAG_SNDH) begin
          mode_d = MODE_TAGS;
          win_d  = '0;
          fill_d = '0;
        end
      end
      MODE_TAGS: begin
        win_d  = shifted;
        fill_d = fill_inc;
        if (fill_inc == 3'd4) begin
          if (shifted == TAG_HDNS) begin
            mode_d = MODE_DONE;
          end else if (shifted == TAG_TITL || shifted == TAG_COMM || shifted == TAG_YEAR) begin
            if (shifted == TAG_TITL) act_d = SID_TITLE;
            else if (shifted == TAG_COMM) act_d = SID_AUTHOR;
            else act_d = SID_YEAR;
            for (int i = 0; i < NUM_STRINGS; i++) begin
              if (act_d == 2'(i)) len_d[i] = '0;
            end
            pos_d  = '0;
            mode_d = MODE_STRING;
            win_d  = '0;
            fill_d = '0;
          end else if (shifted[31:16] == TAG_TUNES || shifted[31:16] == TAG_START) begin
            if (dig_ok) begin
              if (shifted[31:16] == TAG_TUNES) tunes_d = dig_val;
              else start_d = dig_val;
            end
            win_d  = '0;
            fill_d = '0;
          end else if (shifted[31:16] == TAG_TC) begin
            if (shifted[15:0] != 16'd0) hz_d = shifted[15:0];
            win_d  = '0;
            fill_d = '0;
          end else begin
            // unknown tag: keep the last three bytes and slide
            fill_d = 3'd3;
          end
        end
      end
      MODE_STRING: begin
        if (b == 8'd0) begin
          mode_d = MODE_TAGS;
          win_d  = '0;
          fill_d = '0;
        end else if ({1'b0, pos_q} + 7'd1 < cap_of(act_q)) begin
          emit  = 1'b1;
          pos_d = pos_q + 6'd1;
          for (int i = 0; i < NUM_STRINGS; i++) begin
            if (act_q == 2'(i)) len_d[i] = pos_q + 6'd1;
          end
        end
      end
      MODE_DONE: begin
      end
      default: begin
        mode_d = MODE_SEARCH;
      end
    endcase

    ok = (mode_d != MODE_SEARCH) && (cnt_d >= MIN_FILE_LEN);

    ent.has_char       = emit;
    ent.char_sid       = act_q;
    ent.char_idx       = pos_q;
    ent.char_val       = b;
    ent.has_sum        = in_data_i.last_byte;
    ent.sum_ok         = ok;
    ent.sum_tunes      = ok ? tunes_d : '0;
    ent.sum_start      = ok ? start_d : '0;
    ent.sum_hz         = ok ? hz_d : '0;
    ent.sum_title_len  = ok ? len_d[0] : '0;
    ent.sum_author_len = ok ? len_d[1] : '0;
    ent.sum_year_len   = ok ? len_d[2] : '0;

    // end of file: start over for the next one
    if (in_data_i.last_byte) begin
      mode_d  = MODE_SEARCH;
      win_d   = '0;
      fill_d  = '0;
      cnt_d   = '0;
      act_d   = '0;
      pos_d   = '0;
      len_d   = '0;
      tunes_d = DEFAULT_TUNE;
      start_d = DEFAULT_TUNE;
      hz_d    = DEFAULT_HZ;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_SEARCH;
      win_q   <= '0;
      fill_q  <= '0;
      cnt_q   <= '0;
      act_q   <= '0;
      pos_q   <= '0;
      len_q   <= '0;
      tunes_q <= DEFAULT_TUNE;
      start_q <= DEFAULT_TUNE;
      hz_q    <= DEFAULT_HZ;
    end else if (fire) begin
      mode_q  <= mode_d;
      win_q   <= win_d;
      fill_q  <= fill_d;
      cnt_q   <= cnt_d;
      act_q   <= act_d;
      pos_q   <= pos_d;
      len_q   <= len_d;
      tunes_q <= tunes_d;
      start_q <= start_d;
      hz_q    <= hz_d;
    end
  end

  a_last_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && in_data_i.last_byte) |=> (mode_q == MODE_SEARCH && cnt_q == 10'd0))
    else $error("front did not restart after last byte");

  a_pos_in_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == MODE_STRING) |-> ({1'b0, pos_q} < cap_of(act_q)))
    else $error("string position beyond capacity");

endmodule
`default_nettype wire

/* src/sndhtp_queue.sv */
`default_nettype none
module sndhtp_queue
  import sndhtp_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  push_valid_i,
  input  wire qent_t push_data_i,
  output logic       push_ready_o,
  output logic       pop_valid_o,
  output qent_t      pop_data_o,
  input  wire logic  pop_ready_i
);

  qent_t             mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] cnt_q;
  logic              do_push, do_pop;

  assign push_ready_o = (cnt_q != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) cnt_q <= cnt_q + 1'b1;
      else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
    end
  end

  a_no_overfill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue count beyond depth");

  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_valid_i && !push_ready_o))
    else $error("request pushed into full queue");

  a_entry_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_valid_o |-> (pop_data_o.has_char || pop_data_o.has_sum))
    else $error("queue entry carries no result");

endmodule
`default_nettype wire

/* src/sndhtp_back.sv */
`default_nettype none
module sndhtp_back
  import sndhtp_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  pop_valid_i,
  input  wire qent_t pop_data_i,
  output logic       pop_ready_o,
  output logic       out_valid_o,
  output res_t       out_data_o,
  input  wire logic  out_ready_i
);

  logic out_valid_q;
  res_t out_q;
  logic pend_q;
  res_t pend_res_q;
  logic load;
  logic take;
  res_t char_res, sum_res;

  assign load        = !out_valid_q || out_ready_i;
  assign pop_ready_o = load && !pend_q;
  assign take        = pop_ready_o && pop_valid_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    char_res             = '0;
    char_res.result_type = RES_CHAR;
    char_res.string_id   = pop_data_i.char_sid;
    char_res.char_index  = pop_data_i.char_idx;
    char_res.char_value  = pop_data_i.char_val;

    sum_res                 = '0;
    sum_res.result_type     = RES_SUMMARY;
    sum_res.parse_ok        = pop_data_i.sum_ok;
    sum_res.subtune_count   = pop_data_i.sum_tunes;
    sum_res.default_subtune = pop_data_i.sum_start;
    sum_res.timer_hz        = pop_data_i.sum_hz;
    sum_res.title_length    = pop_data_i.sum_title_len;
    sum_res.author_length   = pop_data_i.sum_author_len;
    sum_res.year_length     = pop_data_i.sum_year_len;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      pend_q      <= 1'b0;
    end else if (load) begin
      if (pend_q) begin
        out_valid_q <= 1'b1;
        pend_q      <= 1'b0;
      end else if (pop_valid_i) begin
        out_valid_q <= 1'b1;
        pend_q      <= pop_data_i.has_char && pop_data_i.has_sum;
      end else begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // character goes first, the summary of the same byte waits one slot
  always_ff @(posedge clk_i) begin
    if (load) begin
      if (pend_q) begin
        out_q <= pend_res_q;
      end else if (take) begin
        out_q      <= pop_data_i.has_char ? char_res : sum_res;
        pend_res_q <= sum_res;
      end
    end
  end

  a_pend_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> out_valid_q)
    else $error("pending summary without a result in the output register");

  a_pend_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && pend_q) |=>
      (out_valid_o && out_data_o.result_type == RES_SUMMARY))
    else $error("pending summary not delivered next");

  a_no_pop_with_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> !pop_ready_o)
    else $error("queue popped while a summary is pending");

endmodule
`default_nettype wire

/* src/sndh_header_tag_parser_core.sv */
`default_nettype none
// Header tag parser: takes one file byte per request on the in channel and
// returns captured title, author and year characters and, on the byte marked
// last, one summary request on the out channel. A byte is taken every cycle;
// the front end does the magic search, the four-byte tag window and the
// string capture in a single cycle per byte and hands each byte that yields
// results to a four-entry queue. The back end drives one result per cycle
// while the receiver is ready, from an output register; a last byte that also
// yields a character gives two results, character first. Input stalls only
// when the queue is full; results pass through the queue and output register.
module sndh_header_tag_parser_core
  import sndhtp_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  in_valid_i,
  input  wire item_t in_data_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  output res_t       out_data_o,
  input  wire logic  out_ready_i
);

  logic  push_valid, push_ready;
  qent_t push_data;
  logic  pop_valid, pop_ready;
  qent_t pop_data;

  sndhtp_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_data_i    (in_data_i),
    .in_ready_o   (in_ready_o),
    .push_valid_o (push_valid),
    .push_data_o  (push_data),
    .push_ready_i (push_ready)
  );

  sndhtp_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_data_i  (push_data),
    .push_ready_o (push_ready),
    .pop_valid_o  (pop_valid),
    .pop_data_o   (pop_data),
    .pop_ready_i  (pop_ready)
  );

  sndhtp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_data_i  (pop_data),
    .pop_ready_o (pop_ready),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .out_ready_i (out_ready_i)
  );

endmodule
`default_nettype wire

/* verif/tb_sndh_header_tag_parser_core.sv */
`timescale 1ns / 100ps
module tb_sndh_header_tag_parser_core;
  import sndhtp_pkg::*;

  localparam int RANDOM_BYTES = 850;
  localparam int STALL_LIMIT  = 3000;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 20;

  typedef struct packed {
    item_t item;
    logic  wait_idle;
  } pend_t;

  logic  clk_i = 1'b0;
  logic  rst_ni = 1'b0;
  logic  drv_valid = 1'b0;
  item_t drv_item = '0;
  logic  in_ready;
  logic  out_valid;
  res_t  out_data;
  logic  rcv_ready = 1'b0;

  sndh_header_tag_parser_core u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (drv_valid),
    .in_data_i  (drv_item),
    .in_ready_o (in_ready),
    .out_valid_o(out_valid),
    .out_data_o (out_data),
    .out_ready_i(rcv_ready)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  pend_t      byte_feed_q[$];
  logic [7:0] file_q[$];
  res_t       expected_res_q[$];

  // parser shadow state
  mode_e       p_mode;
  logic [31:0] p_win;
  logic [2:0]  p_fill;
  logic [9:0]  p_count;
  logic [1:0]  p_sid;
  logic [5:0]  p_pos;
  logic [5:0]  p_len [NUM_STRINGS];
  logic [6:0]  p_tunes;
  logic [6:0]  p_start;
  logic [15:0] p_hz;

  int files_sent = 0;
  int bytes_sent = 0;
  int chars_expected = 0;
  int summaries_expected = 0;
  int summaries_ok = 0;
  int results_seen = 0;
  int mismatch_cnt = 0;
  int unexpected_cnt = 0;
  int holds_done = 0;

  task automatic clear_parser();
    p_mode  = MODE_SEARCH;
    p_win   = '0;
    p_fill  = '0;
    p_count = '0;
    p_sid   = SID_TITLE;
    p_pos   = '0;
    for (int i = 0; i < NUM_STRINGS; i++) p_len[i] = '0;
    p_tunes = DEFAULT_TUNE;
    p_start = DEFAULT_TUNE;
    p_hz    = DEFAULT_HZ;
  endtask

  // advance the shadow parser by one byte and queue the results it yields
  task automatic advance_parser(input item_t it);
    res_t       r;
    logic [7:0] b;
    logic [7:0] hi;
    logic [7:0] lo;
    logic [15:0] top;
    int         cap;
    int         v;
    b = it.data_byte;
    if (p_count < COUNT_MAX) p_count++;
    case (p_mode)
      MODE_SEARCH: begin
        p_win = {p_win[23:0], b};
        if (p_fill < 3'd4) p_fill++;
        if (p_fill >= 3'd4 && int'(p_count) <= MAGIC_SEARCH_LIMIT && p_win == TAG_SNDH) begin
          p_mode = MODE_TAGS;
          p_win  = '0;
          p_fill = '0;
        end
      end
      MODE_TAGS: begin
        p_win = {p_win[23:0], b};
        if (p_fill < 3'd4) p_fill++;
        if (p_fill >= 3'd4) begin
          top = p_win[31:16];
          if (p_win == TAG_HDNS) begin
            p_mode = MODE_DONE;
          end else if (p_win == TAG_TITL || p_win == TAG_COMM || p_win == TAG_YEAR) begin
            if (p_win == TAG_TITL) p_sid = SID_TITLE;
            else if (p_win == TAG_COMM) p_sid = SID_AUTHOR;
            else p_sid = SID_YEAR;
            p_pos        = '0;
            p_len[p_sid] = '0;
            p_mode       = MODE_STRING;
            p_win        = '0;
            p_fill       = '0;
          end else if (top == TAG_TUNES || top == TAG_START) begin
            hi = p_win[15:8];
            lo = p_win[7:0];
            if (hi >= 8'h30 && hi <= 8'h39 && lo >= 8'h30 && lo <= 8'h39) begin
              v = (int'(hi) - 48) * 10 + (int'(lo) - 48);
              if (top == TAG_TUNES) p_tunes = 7'(v);
              else p_start = 7'(v);
            end
            p_win  = '0;
            p_fill = '0;
          end else if (top == TAG_TC) begin
            if (p_win[15:0] != 16'd0) p_hz = p_win[15:0];
            p_win  = '0;
            p_fill = '0;
          end else begin
            // unknown window slides by one byte
            p_fill = 3'd3;
          end
        end
      end
      MODE_STRING: begin
        case (p_sid)
          SID_TITLE:  cap = TITLE_CHARS;
          SID_AUTHOR: cap = AUTHOR_CHARS;
          default:    cap = YEAR_CHARS;
        endcase
        if (b == 8'd0) begin
          p_mode = MODE_TAGS;
          p_win  = '0;
          p_fill = '0;
        end else if (int'(p_pos) + 1 < cap) begin
          r             = '0;
          r.result_type = RES_CHAR;
          r.string_id   = p_sid;
          r.char_index  = p_pos;
          r.char_value  = b;
          expected_res_q.push_back(r);
          chars_expected++;
          p_pos        = p_pos + 6'd1;
          p_len[p_sid] = p_pos;
        end
      end
      default: ;
    endcase
    if (it.last_byte) begin
      r             = '0;
      r.result_type = RES_SUMMARY;
      if (p_mode != MODE_SEARCH && p_count >= MIN_FILE_LEN) begin
        r.parse_ok        = 1'b1;
        r.subtune_count   = p_tunes;
        r.default_subtune = p_start;
        r.timer_hz        = p_hz;
        r.title_length    = p_len[SID_TITLE];
        r.author_length   = p_len[SID_AUTHOR];
        r.year_length     = p_len[SID_YEAR];
        summaries_ok++;
      end
      expected_res_q.push_back(r);
      summaries_expected++;
      clear_parser();
    end
  endtask

  task automatic put_text(input string s);
    for (int i = 0; i < s.len(); i++) file_q.push_back(s[i]);
  endtask

  task automatic put_rand(input int n, input bit nonzero);
    for (int i = 0; i < n; i++) begin
      if (nonzero) file_q.push_back(8'($urandom_range(1, 255)));
      else file_q.push_back(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic put_digit();
    // mostly a valid ascii digit, sometimes any byte
    if ($urandom_range(0, 7) == 0) file_q.push_back(8'($urandom_range(0, 255)));
    else file_q.push_back(8'($urandom_range(48, 57)));
  endtask

  task automatic ship_file(input bit hold);
    pend_t p;
    if (file_q.size() == 0) file_q.push_back(8'($urandom_range(0, 255)));
    for (int i = 0; i < file_q.size(); i++) begin
      p.item.data_byte = file_q[i];
      p.item.last_byte = (i == file_q.size() - 1);
      p.wait_idle      = hold && (i == 0);
      byte_feed_q.push_back(p);
    end
    bytes_sent += file_q.size();
    files_sent++;
    file_q.delete();
  endtask

  task automatic make_file();
    int kind;
    int sel;
    int len;
    kind = $urandom_range(0, 9);
    if (kind == 0) begin
      // no magic at all
      put_rand($urandom_range(1, 30), 1'b0);
    end else begin
      put_rand($urandom_range(0, 5), 1'b0);
      put_text("SNDH");
      if (kind == 1) begin
        // likely shorter than the minimum length
        if ($urandom_range(0, 1) != 0) begin
          put_text("TITL");
          put_rand($urandom_range(0, 6), 1'b1);
        end else begin
          put_rand($urandom_range(0, 6), 1'b0);
        end
      end else begin
        repeat ($urandom_range(1, 6)) begin
          sel = $urandom_range(0, 7);
          if (sel <= 2) begin
            case (sel)
              0:       put_text("TITL");
              1:       put_text("COMM");
              default: put_text("YEAR");
            endcase
            if ($urandom_range(0, 4) == 0) len = $urandom_range(25, 70);
            else len = $urandom_range(0, 10);
            put_rand(len, 1'b1);
            file_q.push_back(8'h00);
          end else if (sel <= 4) begin
            if (sel == 3) put_text("##");
            else put_text("!#");
            put_digit();
            put_digit();
          end else if (sel == 5) begin
            put_text("TC");
            if ($urandom_range(0, 3) == 0) begin
              file_q.push_back(8'h00);
              file_q.push_back(8'h00);
            end else begin
              put_rand(2, 1'b0);
            end
          end else begin
            put_rand($urandom_range(1, 3), 1'b0);
          end
        end
        if (kind == 2) begin
          // file ends in an open string or a partial window
          if ($urandom_range(0, 1) != 0) begin
            put_text("COMM");
            put_rand($urandom_range(1, 8), 1'b1);
          end else begin
            put_text("TI");
          end
        end else if ($urandom_range(0, 2) != 0) begin
          put_text("HDNS");
          put_rand($urandom_range(0, 6), 1'b0);
        end
      end
    end
  endtask

  // sender: bursts of random length with random gaps
  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    logic  nxt_valid;
    item_t nxt_item;
    if (!rst_ni) begin
      drv_valid <= 1'b0;
      drv_item  <= '0;
    end else begin
      nxt_valid = drv_valid;
      nxt_item  = drv_item;
      if (drv_valid && in_ready) begin
        advance_parser(drv_item);
        void'(byte_feed_q.pop_front());
        nxt_valid = 1'b0;
      end
      if (!nxt_valid) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (byte_feed_q.size() != 0 &&
                     (!byte_feed_q[0].wait_idle || expected_res_q.size() == 0)) begin
          nxt_valid = 1'b1;
          nxt_item  = byte_feed_q[0].item;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 40);
            gap_left   = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 12) : 0;
          end
        end
      end
      drv_valid <= nxt_valid;
      drv_item  <= nxt_item;
    end
  end

  // receiver: stall pattern that changes now and then, plus long hold-offs
  int rdy_mode = 0;
  int mode_left = 0;
  int hold_left = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    res_t exp_r;
    logic nxt_ready;
    logic took;
    if (!rst_ni) begin
      rcv_ready <= 1'b0;
    end else begin
      took = out_valid && rcv_ready;
      if (took) begin
        results_seen++;
        if (expected_res_q.size() == 0) begin
          unexpected_cnt++;
          if (mismatch_cnt + unexpected_cnt <= 10)
            $display("unexpected result: %h", out_data);
        end else begin
          exp_r = expected_res_q.pop_front();
          if (out_data.result_type !== exp_r.result_type ||
              out_data.string_id !== exp_r.string_id ||
              out_data.char_index !== exp_r.char_index ||
              out_data.char_value !== exp_r.char_value ||
              out_data.parse_ok !== exp_r.parse_ok ||
              out_data.subtune_count !== exp_r.subtune_count ||
              out_data.default_subtune !== exp_r.default_subtune ||
              out_data.timer_hz !== exp_r.timer_hz ||
              out_data.title_length !== exp_r.title_length ||
              out_data.author_length !== exp_r.author_length ||
              out_data.year_length !== exp_r.year_length) begin
            mismatch_cnt++;
            if (mismatch_cnt + unexpected_cnt <= 10) begin
              $display("mismatch at result %0d: exp %h got %h", results_seen, exp_r, out_data);
              $display("  exp type %0d sid %0d idx %0d chr %h ok %0d tunes %0d start %0d hz %0d",
                       exp_r.result_type, exp_r.string_id, exp_r.char_index,
                       exp_r.char_value, exp_r.parse_ok, exp_r.subtune_count,
                       exp_r.default_subtune, exp_r.timer_hz);
              $display("  got type %0d sid %0d idx %0d chr %h ok %0d tunes %0d start %0d hz %0d",
                       out_data.result_type, out_data.string_id, out_data.char_index,
                       out_data.char_value, out_data.parse_ok, out_data.subtune_count,
                       out_data.default_subtune, out_data.timer_hz);
            end
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        nxt_ready = 1'b0;
      end else if (took && holds_done < 2 && out_data.result_type == RES_CHAR &&
                   out_data.char_index >= 6'd6 &&
                   results_seen >= ((holds_done == 0) ? 120 : 700)) begin
        // inside a long string: stop taking results so the input backs up
        hold_left = HOLD_CYCLES;
        holds_done++;
        nxt_ready = 1'b0;
      end else begin
        if (mode_left == 0) begin
          rdy_mode  = $urandom_range(0, 3);
          mode_left = $urandom_range(16, 120);
        end else begin
          mode_left--;
        end
        case (rdy_mode)
          0:       nxt_ready = 1'b1;
          1:       nxt_ready = 1'($urandom_range(0, 1));
          2:       nxt_ready = ($urandom_range(0, 3) == 0);
          default: nxt_ready = ~rcv_ready;
        endcase
      end
      rcv_ready <= nxt_ready;
    end
  end

  int quiet_cycles = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((drv_valid && in_ready) || (out_valid && rcv_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("timeout: no progress for %0d cycles", STALL_LIMIT);
        $display("tb_sndh_header_tag_parser_core NOT OK");
        $finish;
      end
    end
  end

  initial begin
    int random_start;
    clear_parser();

    // full header with extreme values, ends after HDNS
    put_text("SNDHYEARZ");
    file_q.push_back(8'h00);
    put_text("##99TC");
    file_q.push_back(8'hFF);
    file_q.push_back(8'hFF);
    put_text("HDNS");
    file_q.push_back(8'h00);
    ship_file(1'b0);
    // short file with magic, last byte is also a captured character
    put_text("SNDHTITL");
    file_q.push_back(8'h80);
    ship_file(1'b1);

    random_start = bytes_sent;
    while (bytes_sent - random_start < RANDOM_BYTES) begin
      make_file();
      ship_file((files_sent % 12) == 11);
      if (files_sent == 8) begin
        // magic ending exactly at the search limit
        put_rand(MAGIC_SEARCH_LIMIT - 4, 1'b0);
        put_text("SNDHTITLok");
        file_q.push_back(8'h00);
        put_text("!#07");
        ship_file(1'b1);
      end else if (files_sent == 30) begin
        // magic just past the limit, and a length beyond the counter range
        put_rand(MAGIC_SEARCH_LIMIT - 3, 1'b0);
        put_text("SNDH");
        put_rand(590, 1'b0);
        put_text("SNDHTITLx");
        ship_file(1'b0);
      end
    end

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (byte_feed_q.size() != 0 || expected_res_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("sent %0d files, %0d bytes; checked %0d results (%0d characters, %0d summaries)",
             files_sent, bytes_sent, results_seen, chars_expected, summaries_expected);
    $display("%0d summaries with a good parse, %0d long receiver hold-offs, %0d errors",
             summaries_ok, holds_done,
             mismatch_cnt + unexpected_cnt + expected_res_q.size());
    if (mismatch_cnt == 0 && unexpected_cnt == 0 && expected_res_q.size() == 0) begin
      $display("tb_sndh_header_tag_parser_core OK");
    end else begin
      $display("tb_sndh_header_tag_parser_core NOT OK");
    end
    $finish;
  end

endmodule
